### rtl/core/nif_pkg.sv
// Package for the NEC infrared frame decoder: phase codes, register indexes,
// configuration and result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nif_pkg;

    localparam int unsigned FRAME_BITS  = 32;
    localparam int unsigned CNT_W       = $clog2(FRAME_BITS);
    localparam int unsigned IV_W        = 16;
    localparam int unsigned WIN_W       = 12;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW = 3'd0,
        REG_START  = 3'd1,
        REG_REPEAT = 3'd2,
        REG_ZERO   = 3'd3,
        REG_ONE    = 3'd4
    } cfg_idx_t;

    // Decoder phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_WAIT = 3'b010,
        PH_RECV = 3'b100
    } phase_t;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [IV_W-1:0]  start_ticks;
        logic [IV_W-1:0]  repeat_ticks;
        logic [IV_W-1:0]  zero_ticks;
        logic [IV_W-1:0]  one_ticks;
    } cfg_t;

    typedef struct packed {
        logic              is_repeat;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/nif_near.sv
// Window compare: nominal - window < interval < nominal + window.
// Depends on nif_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nif_near
    import nif_pkg::*;
(
    input  wire logic [IV_W-1:0]  interval,
    input  wire logic [IV_W-1:0]  nominal,
    input  wire logic [WIN_W-1:0] window,
    output logic                  hit
);

    logic [IV_W:0] iv_plus_win;
    logic [IV_W:0] nom_plus_win;

    // Both sides moved by the window so nothing goes negative.
    assign iv_plus_win  = {1'b0, interval} + {{(IV_W + 1 - WIN_W){1'b0}}, window};
    assign nom_plus_win = {1'b0, nominal}  + {{(IV_W + 1 - WIN_W){1'b0}}, window};

    assign hit = (iv_plus_win > {1'b0, nominal}) && ({1'b0, interval} < nom_plus_win);

endmodule

`default_nettype wire

### rtl/core/nif_step.sv
// Per-edge decode: phase machine, bit shifter, frame check and last-frame store.
// Depends on nif_pkg and nif_near.
`timescale 1ns / 1ps
`default_nettype none

module nif_step
    import nif_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic [IV_W-1:0] interval,
    input  wire cfg_t            cfg,
    output logic                 res_valid,
    output result_t              res
);

    phase_t                  phase_reg, phase_next;
    logic [CNT_W-1:0]        bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next;
    logic [BYTE_W-1:0]       last_addr_reg, last_addr_next;
    logic [BYTE_W-1:0]       last_cmd_reg, last_cmd_next;

    logic hit_start, hit_repeat, hit_zero, hit_one;
    logic [FRAME_BITS-1:0] shifted;
    logic [BYTE_W-1:0] b0, b1, b2, b3;

    nif_near u_near_start  (.interval(interval), .nominal(cfg.start_ticks),
                            .window(cfg.window), .hit(hit_start));
    nif_near u_near_repeat (.interval(interval), .nominal(cfg.repeat_ticks),
                            .window(cfg.window), .hit(hit_repeat));
    nif_near u_near_zero   (.interval(interval), .nominal(cfg.zero_ticks),
                            .window(cfg.window), .hit(hit_zero));
    nif_near u_near_one    (.interval(interval), .nominal(cfg.one_ticks),
                            .window(cfg.window), .hit(hit_one));

    // Frame with the current bit written at position bit_count.
    always_comb begin
        shifted = frame_reg;
        shifted[bit_count_reg] = !hit_zero;
    end

    assign b0 = shifted[BYTE_W-1:0];
    assign b1 = shifted[2*BYTE_W-1:BYTE_W];
    assign b2 = shifted[3*BYTE_W-1:2*BYTE_W];
    assign b3 = shifted[4*BYTE_W-1:3*BYTE_W];

    always_comb begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        frame_next     = frame_reg;
        last_addr_next = last_addr_reg;
        last_cmd_next  = last_cmd_reg;
        res_valid      = 1'b0;
        res.is_repeat  = 1'b0;
        res.address    = last_addr_reg;
        res.command    = last_cmd_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_WAIT: begin
                    priority if (hit_start) begin
                        phase_next = PH_RECV;
                    end else if (hit_repeat) begin
                        phase_next    = PH_IDLE;
                        res_valid     = 1'b1;
                        res.is_repeat = 1'b1;
                    end
                end
                PH_RECV: begin
                    if (hit_zero || hit_one) begin
                        frame_next     = shifted;
                        bit_count_next = bit_count_reg + 1'b1;
                        if (bit_count_reg == CNT_W'(FRAME_BITS - 1)) begin
                            phase_next = PH_IDLE;
                            if ((b0 == ~b1) && (b2 == ~b3)) begin
                                last_addr_next = b0;
                                last_cmd_next  = b2;
                                res_valid      = 1'b1;
                                res.address    = b0;
                                res.command    = b2;
                            end
                        end
                    end else begin
                        phase_next     = PH_WAIT;
                        bit_count_next = '0;
                    end
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            frame_reg     <= '0;
            last_addr_reg <= '0;
            last_cmd_reg  <= '0;
        end else begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            frame_reg     <= frame_next;
            last_addr_reg <= last_addr_next;
            last_cmd_reg  <= last_cmd_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder: configuration registers and
// the result register. Depends on nif_pkg and nif_step.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                    Moves
// input     s_valid, s_ready, s_interval             one falling-edge item
// result    m_valid, m_ready, m_is_repeat, ...       one decoded frame or repeat
// config    cfg_wr_en, cfg_index, cfg_wdata          one register write
//
// Each input item is decoded combinationally; a result appears in the result
// register on the cycle after its item is accepted. The rate of one item per
// cycle holds while results are taken; it is set by the result register,
// loaded as it drains, so s_ready is high whenever it is empty or being taken.
// Reset (synchronous, active low) returns to idle, clears the last frame and
// loads the default timing registers.

module nec_ir_frame_decoder
    import nif_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [IV_W-1:0]       s_interval,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_is_repeat,
    output logic [BYTE_W-1:0]          m_address,
    output logic [BYTE_W-1:0]          m_command,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t    cfg_reg, cfg_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    accept;
    logic    step_valid;
    result_t step_res;

    // An item enters whenever the result register is free this cycle.
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    nif_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .interval  (s_interval),
        .cfg       (cfg_reg),
        .res_valid (step_valid),
        .res       (step_res)
    );

    // Register writes; an index beyond the list is ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WINDOW: cfg_next.window       = cfg_wdata[WIN_W-1:0];
                REG_START:  cfg_next.start_ticks  = cfg_wdata;
                REG_REPEAT: cfg_next.repeat_ticks = cfg_wdata;
                REG_ZERO:   cfg_next.zero_ticks   = cfg_wdata;
                REG_ONE:    cfg_next.one_ticks    = cfg_wdata;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // The result register holds until taken, and is refilled in the same
    // cycle when a new item yields a result.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept && step_valid) begin
            out_valid_next = 1'b1;
            out_next       = step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window       <= WIN_W'(300);
            cfg_reg.start_ticks  <= IV_W'(12442);
            cfg_reg.repeat_ticks <= IV_W'(10368);
            cfg_reg.zero_ticks   <= IV_W'(1032);
            cfg_reg.one_ticks    <= IV_W'(2074);
            out_valid_reg        <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_is_repeat = out_reg.is_repeat;
    assign m_address   = out_reg.address;
    assign m_command   = out_reg.command;

endmodule

`default_nettype wire
